// File: rtl/afc_pkg.sv
// afc_pkg: shared types and constants for the audio frame counter
// depends on nothing; used by afc_ctrl, afc_dp, audio_frame_count and afc_checker

package afc_pkg;

	localparam int LEN_BITS   = 16;
	localparam int STEP_BITS  = 16;
	localparam int COUNT_BITS = 32;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] CFG_FRAME_LEN  = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_FRAME_STEP = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_SNIP_MODE  = 2'd2;

	localparam logic [LEN_BITS-1:0]  FRAME_LEN_RST  = 16'd400;
	localparam logic [STEP_BITS-1:0] FRAME_STEP_RST = 16'd160;
	localparam logic                 SNIP_MODE_RST  = 1'b1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic iter;
		logic fix;
	} afc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic div_busy;
	} afc_status_t;

endpackage

// File: rtl/afc_ctrl.sv
// afc_ctrl: sequencing state machine for one frame count request
// depends on afc_pkg (command and status types)

module afc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_free,
	input  afc_pkg::afc_status_t  status,
	output afc_pkg::afc_cmd_t     cmd,
	output logic                  emit
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_FIX,
		S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.div_last) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.prep = (state_q == S_PREP);
		cmd.iter = (state_q == S_DIV) && status.div_busy;
		cmd.fix  = (state_q == S_FIX);
		emit     = (state_q == S_DONE) && out_free;
	end

endmodule

// File: rtl/afc_dp.sv
// afc_dp: operand registers, two-lane radix-2 restoring divider and count fixup
// depends on afc_pkg (command and status types, widths, count limit)

module afc_dp #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  afc_pkg::afc_cmd_t                 cmd,
	output afc_pkg::afc_status_t              status,
	input  logic [SAMPLE_BITS-1:0]            sample_total,
	input  logic                              flush_all,
	input  logic [afc_pkg::LEN_BITS-1:0]      frame_len,
	input  logic [afc_pkg::STEP_BITS-1:0]     frame_step,
	input  logic                              snip_mode,
	output logic [afc_pkg::COUNT_BITS-1:0]    frame_total_nxt
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int RW = (DW + 1 > afc_pkg::COUNT_BITS + 1) ? DW + 1 : afc_pkg::COUNT_BITS + 1;
	localparam int CW = $clog2(DW + 1);
	localparam int SW = afc_pkg::STEP_BITS;

	logic [SAMPLE_BITS-1:0]         n_q;
	logic [afc_pkg::LEN_BITS-1:0]   len_q;
	logic [SW-1:0]                  step_q;
	logic                           snip_q;
	logic                           flush_q;

	logic [DW-1:0]                  dvd_a_q;
	logic [DW-1:0]                  dvd_b_q;
	logic [SW-1:0]                  rem_a_q;
	logic [SW-1:0]                  rem_b_q;
	logic                           neg_a_q;
	logic                           neg_b_q;
	logic [CW-1:0]                  cnt_q;
	logic                           busy_q;

	logic [RW-1:0]                  cand_q;
	logic [RW-1:0]                  fit_q;

	logic [SW-1:0]                  half;
	logic [SW:0]                    reach;
	logic [DW-1:0]                  n_ext;
	logic [DW-1:0]                  len_ext;
	logic [DW-1:0]                  reach_ext;
	logic [SW:0]                    remsh_a;
	logic [SW:0]                    remsh_b;
	logic                           ge_a;
	logic                           ge_b;
	logic [SW:0]                    diff_a;
	logic [SW:0]                    diff_b;
	logic                           trim;
	logic [RW-1:0]                  res;

	always_comb begin
		half      = step_q >> 1;
		reach     = {1'b0, half} + (SW+1)'(len_q - (len_q >> 1));
		n_ext     = {1'b0, n_q};
		len_ext   = DW'(len_q);
		reach_ext = DW'(reach);

		remsh_a = {rem_a_q, dvd_a_q[DW-1]};
		remsh_b = {rem_b_q, dvd_b_q[DW-1]};
		ge_a    = remsh_a >= {1'b0, step_q};
		ge_b    = remsh_b >= {1'b0, step_q};
		diff_a  = remsh_a - {1'b0, step_q};
		diff_b  = remsh_b - {1'b0, step_q};

		status.div_last = busy_q && (cnt_q == CW'(DW - 1));
		status.div_busy = busy_q;

		trim = !snip_q && !flush_q && (cand_q != '0) && (fit_q < cand_q);
		res  = trim ? fit_q : cand_q;
		frame_total_nxt = (res > RW'(afc_pkg::COUNT_MAX)) ? afc_pkg::COUNT_MAX
		                                                    : res[afc_pkg::COUNT_BITS-1:0];
	end

	// operand capture, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= sample_total;
			flush_q <= flush_all;
			len_q   <= frame_len;
			step_q  <= (frame_step == '0) ? SW'(1) : frame_step;
			snip_q  <= snip_mode;
		end
	end

	// divider lanes: a = count dividend, b = last-frame fit dividend
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_a_q <= '0;
			rem_b_q <= '0;
			if (snip_q) begin
				dvd_a_q <= n_ext - len_ext;
				neg_a_q <= n_ext < len_ext;
			end else begin
				dvd_a_q <= n_ext + DW'(half);
				neg_a_q <= 1'b0;
			end
			dvd_b_q <= n_ext - reach_ext;
			neg_b_q <= reach_ext > n_ext;
		end else if (cmd.iter) begin
			rem_a_q <= ge_a ? diff_a[SW-1:0] : remsh_a[SW-1:0];
			rem_b_q <= ge_b ? diff_b[SW-1:0] : remsh_b[SW-1:0];
			dvd_a_q <= {dvd_a_q[DW-2:0], ge_a};
			dvd_b_q <= {dvd_b_q[DW-2:0], ge_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.prep) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (cmd.iter) begin
			cnt_q <= cnt_q + CW'(1);
			if (status.div_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// candidate count and fit bound
	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			if (snip_q) begin
				cand_q <= neg_a_q ? '0 : RW'(dvd_a_q) + RW'(1);
			end else begin
				cand_q <= RW'(dvd_a_q);
			end
			fit_q <= neg_b_q ? '0 : RW'(dvd_b_q) + RW'(1);
		end
	end

endmodule

// File: rtl/audio_frame_count.sv
// audio_frame_count: analysis frame count from waveform length, top level
// a request passes the prep, divide, fixup and done states in order before its result is registered
// only one request is in work at a time; the divider produces one quotient bit per cycle in each lane
// the result register lets a new request start while the previous result waits
// reset: arst_n asynchronous active low; config returns to 400 / 160 / snip, no result held
// depends on afc_pkg, afc_ctrl, afc_dp

module audio_frame_count #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [afc_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [afc_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample_total,
	input  logic                              flush_all,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [afc_pkg::COUNT_BITS-1:0]    frame_total
);

	logic [afc_pkg::LEN_BITS-1:0]    frame_len_q;
	logic [afc_pkg::STEP_BITS-1:0]   frame_step_q;
	logic                            snip_mode_q;
	logic                            out_valid_q;
	logic [afc_pkg::COUNT_BITS-1:0]  frame_total_q;

	afc_pkg::afc_cmd_t               cmd;
	afc_pkg::afc_status_t            status;
	logic                            out_free;
	logic                            emit;
	logic [afc_pkg::COUNT_BITS-1:0]  frame_total_nxt;

	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign frame_total = frame_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q  <= afc_pkg::FRAME_LEN_RST;
			frame_step_q <= afc_pkg::FRAME_STEP_RST;
			snip_mode_q  <= afc_pkg::SNIP_MODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				afc_pkg::CFG_FRAME_LEN:  frame_len_q  <= cfg_data;
				afc_pkg::CFG_FRAME_STEP: frame_step_q <= cfg_data;
				afc_pkg::CFG_SNIP_MODE:  snip_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_total_q <= frame_total_nxt;
		end
	end

	afc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.emit     (emit)
	);

	afc_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.sample_total    (sample_total),
		.flush_all       (flush_all),
		.frame_len       (frame_len_q),
		.frame_step      (frame_step_q),
		.snip_mode       (snip_mode_q),
		.frame_total_nxt (frame_total_nxt)
	);

endmodule

// File: rtl/afc_checker.sv
// afc_checker: port-level checks on request and result timing of the frame counter
// depends on afc_pkg (count width); bound to audio_frame_count below

module afc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [afc_pkg::COUNT_BITS-1:0]    frame_total
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_total))
		else $error("result changed or dropped while stalled");

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in work");

	// a new result appears exactly as the engine frees up
	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("result appeared without request finishing");

	// engine is still busy after the prep state, at the start of the divide
	a_min_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !in_ready)
		else $error("request finished too early");

endmodule

bind audio_frame_count afc_checker u_afc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.frame_total (frame_total)
);
